// ===== rtl/tpq_pkg.sv =====
package tpq_pkg;

    // field widths of the stream payload
    localparam int TICKET_W = 16;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W = 16;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 24;

    // operation carried in tuser bit 0 of the input stream
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP = 1'b1;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [TICKET_W-1:0] ticket;
        logic                prio;
        logic [STATUS_W-1:0] status;
        logic                empty;
    } t_result;

endpackage

// ===== rtl/two_class_priority_queue.sv =====
// Two-class ticket queue: priority tickets leave ahead of every normal ticket, and
// each class leaves in arrival order. Each class is a ring buffer in its own
// memory of DEPTH entries with one write port and one registered read port, plus a
// head index and a fill count in flip-flops. A push writes the memory and registers its
// result at the transfer; a pop waits in a read state for the registered memory read, so
// the input accepts one push every cycle while the output drains, but takes no new item
// while a pop is in flight. A finished result sits in an output register, and a new item
// is taken only while that register is empty or is being read out in the same cycle.
// Input tuser: bit 0 opcode (0 push, 1 pop), bit 1 priority class. A push to a full
// class is dropped with status full; a pop on an empty queue returns ticket 0 with
// status empty. Ticket values keep their low TICKET_BITS bits.
module two_class_priority_queue #(
    parameter int DEPTH = 16,
    parameter int TICKET_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [tpq_pkg::IN_DATA_W-1:0]  i_s_tdata,  // [15:0] ticket
    input  logic [tpq_pkg::IN_USER_W-1:0]  i_s_tuser,  // [0] opcode, [1] is_priority
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [tpq_pkg::OUT_DATA_W-1:0] o_m_tdata,  // [15:0] popped_ticket,
                                                       // [17:16] status, [18] queue_empty
    output logic                           o_m_tuser   // [0] popped_priority
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int XW = tpq_pkg::TICKET_W + 32;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic [TICKET_BITS-1:0] r_prio_mem [DEPTH];
    logic [TICKET_BITS-1:0] r_norm_mem [DEPTH];
    logic [TICKET_BITS-1:0] r_prio_rd;
    logic [TICKET_BITS-1:0] r_norm_rd;

    logic          r_state, n_state;
    logic [AW-1:0] r_prio_head, n_prio_head;
    logic [AW-1:0] r_norm_head, n_norm_head;
    logic [CW-1:0] r_prio_count, n_prio_count;
    logic [CW-1:0] r_norm_count, n_norm_count;
    logic          r_pend_prio, n_pend_prio;
    logic          r_pend_empty, n_pend_empty;
    logic          r_out_valid, n_out_valid;
    tpq_pkg::t_result r_out, n_out;

    logic          w_accept;
    logic          w_op;
    logic          w_cls;
    logic [XW-1:0] w_tin_ext;
    logic [TICKET_BITS-1:0] w_tin;
    logic [SW-1:0] w_prio_sum;
    logic [SW-1:0] w_norm_sum;
    logic [AW-1:0] w_prio_tail;
    logic [AW-1:0] w_norm_tail;
    logic          w_prio_full;
    logic          w_norm_full;
    logic          w_prio_wr;
    logic          w_norm_wr;
    logic [TICKET_BITS-1:0] w_rd_sel;
    logic [XW-1:0] w_rd_ext;

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_op       = i_s_tuser[0];
    assign w_cls      = i_s_tuser[1];

    assign w_tin_ext = {32'b0, i_s_tdata[tpq_pkg::TICKET_W-1:0]};
    assign w_tin     = w_tin_ext[TICKET_BITS-1:0];

    // tail slot = (head + count) mod DEPTH, sum stays below twice the depth
    assign w_prio_sum  = SW'(r_prio_head) + SW'(r_prio_count);
    assign w_norm_sum  = SW'(r_norm_head) + SW'(r_norm_count);
    assign w_prio_tail = (w_prio_sum >= SW'(DEPTH)) ? AW'(w_prio_sum - SW'(DEPTH))
                                                    : AW'(w_prio_sum);
    assign w_norm_tail = (w_norm_sum >= SW'(DEPTH)) ? AW'(w_norm_sum - SW'(DEPTH))
                                                    : AW'(w_norm_sum);
    assign w_prio_full = (r_prio_count == CW'(DEPTH));
    assign w_norm_full = (r_norm_count == CW'(DEPTH));

    assign w_prio_wr = w_accept && (w_op == tpq_pkg::OP_PUSH) && w_cls && !w_prio_full;
    assign w_norm_wr = w_accept && (w_op == tpq_pkg::OP_PUSH) && !w_cls && !w_norm_full;

    // both heads are read every cycle; the data from the pop transfer is used next cycle
    always_ff @(posedge i_clk) begin
        if (w_prio_wr) begin
            r_prio_mem[w_prio_tail] <= w_tin;
        end
        r_prio_rd <= r_prio_mem[r_prio_head];
    end

    always_ff @(posedge i_clk) begin
        if (w_norm_wr) begin
            r_norm_mem[w_norm_tail] <= w_tin;
        end
        r_norm_rd <= r_norm_mem[r_norm_head];
    end

    assign w_rd_sel = r_pend_prio ? r_prio_rd : r_norm_rd;
    assign w_rd_ext = {{(XW - TICKET_BITS){1'b0}}, w_rd_sel};

    always_comb begin
        n_state      = r_state;
        n_prio_head  = r_prio_head;
        n_norm_head  = r_norm_head;
        n_prio_count = r_prio_count;
        n_norm_count = r_norm_count;
        n_pend_prio  = r_pend_prio;
        n_pend_empty = r_pend_empty;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_op == tpq_pkg::OP_PUSH) begin
                        n_out.ticket = '0;
                        n_out.prio   = 1'b0;
                        n_out.status = tpq_pkg::ST_OK;
                        if (w_prio_wr) begin
                            n_prio_count = r_prio_count + CW'(1);
                        end else if (w_norm_wr) begin
                            n_norm_count = r_norm_count + CW'(1);
                        end else begin
                            n_out.status = tpq_pkg::ST_FULL;
                        end
                        n_out.empty = (n_prio_count == '0) && (n_norm_count == '0);
                        n_out_valid = 1'b1;
                    end else if (r_prio_count != '0) begin
                        n_prio_count = r_prio_count - CW'(1);
                        n_prio_head  = (r_prio_head == AW'(DEPTH - 1)) ? '0
                                                                        : r_prio_head + AW'(1);
                        n_pend_prio  = 1'b1;
                        n_pend_empty = (n_prio_count == '0) && (r_norm_count == '0);
                        n_state      = S_READ;
                    end else if (r_norm_count != '0) begin
                        n_norm_count = r_norm_count - CW'(1);
                        n_norm_head  = (r_norm_head == AW'(DEPTH - 1)) ? '0
                                                                        : r_norm_head + AW'(1);
                        n_pend_prio  = 1'b0;
                        n_pend_empty = (n_norm_count == '0);
                        n_state      = S_READ;
                    end else begin
                        n_out.ticket = '0;
                        n_out.prio   = 1'b0;
                        n_out.status = tpq_pkg::ST_EMPTY;
                        n_out.empty  = 1'b1;
                        n_out_valid  = 1'b1;
                    end
                end
            end
            S_READ: begin
                // output register is free here: the pop was only taken when it would be
                n_out.ticket = w_rd_ext[tpq_pkg::TICKET_W-1:0];
                n_out.prio   = r_pend_prio;
                n_out.status = tpq_pkg::ST_OK;
                n_out.empty  = r_pend_empty;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prio_head  <= '0;
            r_norm_head  <= '0;
            r_prio_count <= '0;
            r_norm_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prio_head  <= n_prio_head;
            r_norm_head  <= n_norm_head;
            r_prio_count <= n_prio_count;
            r_norm_count <= n_norm_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_prio  <= n_pend_prio;
        r_pend_empty <= n_pend_empty;
        r_out        <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out.empty, r_out.status, r_out.ticket};
    assign o_m_tuser  = r_out.prio;

endmodule
